@@ design/svg_pkg.sv @@
// Package: shared widths, constants and word types for the spatial voice gain block.
`default_nettype none
package svg_pkg;

  localparam int POS_FRAC_BITS  = 12;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int POS_W   = 24;
  localparam int LIM_W   = 23;
  localparam int GAIN_W  = 17;
  localparam int DIFF_W  = POS_W + 1;
  localparam int MAG_W   = DIFF_W;
  localparam int RAD_W   = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int QUO_W   = GAIN_FRAC_BITS + 1;
  localparam int DIV_W   = ROOT_W + 1 + QUO_W;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;

  typedef struct packed {
    logic                    playing;
    logic                    has_sample_data;
    logic                    spatialized;
    logic signed [POS_W-1:0] src_x;
    logic signed [POS_W-1:0] src_y;
    logic signed [POS_W-1:0] src_z;
    logic signed [POS_W-1:0] lis_x;
    logic signed [POS_W-1:0] lis_y;
    logic signed [POS_W-1:0] lis_z;
    logic [LIM_W-1:0]        near_limit;
    logic [LIM_W-1:0]        far_limit;
  } in_word_t;

  typedef struct packed {
    logic [GAIN_W-1:0] distance_gain;
    logic [GAIN_W-1:0] left_gain;
    logic [GAIN_W-1:0] right_gain;
  } out_word_t;

  // Per-stage control that rides with each word.
  typedef struct packed {
    logic valid;
    logic spat;
    logic neg;
  } ctl_t;

endpackage
`default_nettype wire

@@ design/spatial_voice_gain_top.sv @@
// Top level: pipelined distance attenuation and linear pan, one source word per cycle.
// Stages from accepted word to result: 3 front stages, 25 square-root
//   stages, 1 clamp stage, 17 divider stages, 1 output stage.
// Throughput: one word per cycle; the whole pipe advances unless a valid result stalls.
// Sources not playing or without sample data enter as bubbles and give no result.
// Reset (rst, synchronous) clears every stage valid bit; payload is not reset.
`default_nettype none
module spatial_voice_gain_top import svg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_word_t  item,
  output logic           gain_valid,
  input  wire logic      gain_stall,
  output out_word_t      gain
);

  // Global advance: everything moves unless the output word is held.
  logic en;
  assign en         = !(gain_valid && gain_stall);
  assign item_stall = !en;

  // ---------------- Stage 1: deltas and magnitudes ----------------
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [MAG_W-1:0]         ax_c, ay_c, az_c;

  assign dx = DIFF_W'(item.src_x) - DIFF_W'(item.lis_x);
  assign dy = DIFF_W'(item.src_y) - DIFF_W'(item.lis_y);
  assign dz = DIFF_W'(item.src_z) - DIFF_W'(item.lis_z);
  assign ax_c = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign ay_c = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  assign az_c = dz[DIFF_W-1] ? MAG_W'(-dz) : MAG_W'(dz);

  ctl_t             c1;
  logic [MAG_W-1:0] ax1, ay1, az1;
  logic [LIM_W-1:0] near1, far1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
    end else if (en) begin
      c1.valid <= item_valid && item.playing && item.has_sample_data;
    end
    if (en) begin
      c1.spat <= item.spatialized;
      c1.neg  <= dx[DIFF_W-1];
      ax1     <= ax_c;
      ay1     <= ay_c;
      az1     <= az_c;
      near1   <= item.near_limit;
      far1    <= item.far_limit;
    end
  end

  // ---------------- Stage 2: squares ----------------
  ctl_t             c2;
  logic [MAG_W-1:0] ax2;
  logic [LIM_W-1:0] near2, far2;
  logic [RAD_W-1:0] sx2, sy2, sz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.valid <= 1'b0;
    end else if (en) begin
      c2.valid <= c1.valid;
    end
    if (en) begin
      c2.spat <= c1.spat;
      c2.neg  <= c1.neg;
      ax2     <= ax1;
      near2   <= near1;
      far2    <= far1;
      sx2     <= ax1 * ax1;
      sy2     <= ay1 * ay1;
      sz2     <= az1 * az1;
    end
  end

  // ---------------- Stage 3: sum of squares ----------------
  // Index 0 of the root arrays is this stage's output.
  ctl_t             sq_ctl  [0:ROOT_W];
  logic [MAG_W-1:0] sq_ax   [0:ROOT_W];
  logic [LIM_W-1:0] sq_near [0:ROOT_W];
  logic [LIM_W-1:0] sq_far  [0:ROOT_W];
  logic [RAD_W:0]   sq_rem  [0:ROOT_W];
  logic [RAD_W:0]   sq_res  [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl[0].valid <= 1'b0;
    end else if (en) begin
      sq_ctl[0].valid <= c2.valid;
    end
    if (en) begin
      sq_ctl[0].spat <= c2.spat;
      sq_ctl[0].neg  <= c2.neg;
      sq_ax[0]       <= ax2;
      sq_near[0]     <= near2;
      sq_far[0]      <= far2;
      sq_rem[0]      <= (RAD_W+1)'(sx2) + (RAD_W+1)'(sy2) + (RAD_W+1)'(sz2);
      sq_res[0]      <= '0;
    end
  end

  // ---------------- Square root: one result bit per stage ----------------
  // Radicand stays below 4^ROOT_W, so starting at bit 4^(ROOT_W-1) is exact.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W:0] bitv, trial, rem_n, res_n;

    assign bitv  = (RAD_W+1)'(1) << (2 * B);
    assign trial = sq_res[k] + bitv;

    always_comb begin
      if (sq_rem[k] >= trial) begin
        rem_n = sq_rem[k] - trial;
        res_n = (sq_res[k] >> 1) + bitv;
      end else begin
        rem_n = sq_rem[k];
        res_n = sq_res[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_ctl[k+1].valid <= 1'b0;
      end else if (en) begin
        sq_ctl[k+1].valid <= sq_ctl[k].valid;
      end
      if (en) begin
        sq_ctl[k+1].spat <= sq_ctl[k].spat;
        sq_ctl[k+1].neg  <= sq_ctl[k].neg;
        sq_ax[k+1]       <= sq_ax[k];
        sq_near[k+1]     <= sq_near[k];
        sq_far[k+1]      <= sq_far[k];
        sq_rem[k+1]      <= rem_n;
        sq_res[k+1]      <= res_n;
      end
    end
  end

  // ---------------- Clamp stage: limits, divisors, numerators ----------------
  // Near applied first, far second, so far wins on crossed limits.
  logic [ROOT_W-1:0] span, c_near, c_clamp;

  assign span    = sq_res[ROOT_W][ROOT_W-1:0];
  assign c_near  = (span < ROOT_W'(sq_near[ROOT_W])) ? ROOT_W'(sq_near[ROOT_W]) : span;
  assign c_clamp = (c_near > ROOT_W'(sq_far[ROOT_W])) ? ROOT_W'(sq_far[ROOT_W]) : c_near;

  ctl_t             dv_ctl [0:QUO_W];
  logic [DIV_W-1:0] dv_r1  [0:QUO_W];
  logic [DIV_W-1:0] dv_d1  [0:QUO_W];
  logic [QUO_W-1:0] dv_q1  [0:QUO_W];
  logic [DIV_W-1:0] dv_r2  [0:QUO_W];
  logic [DIV_W-1:0] dv_d2  [0:QUO_W];
  logic [QUO_W-1:0] dv_q2  [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0].valid <= 1'b0;
    end else if (en) begin
      dv_ctl[0].valid <= sq_ctl[ROOT_W].valid;
    end
    if (en) begin
      dv_ctl[0].spat <= sq_ctl[ROOT_W].spat;
      dv_ctl[0].neg  <= sq_ctl[ROOT_W].neg;
      // distance gain: 2^(G+P) / (2^P + clamped)
      dv_r1[0] <= DIV_W'(1) << (GAIN_FRAC_BITS + POS_FRAC_BITS);
      dv_d1[0] <= (DIV_W'(1) << POS_FRAC_BITS) + DIV_W'(c_clamp);
      dv_q1[0] <= '0;
      // pan magnitude: |dx| * 2^G / (distance + 1 LSB)
      dv_r2[0] <= DIV_W'(sq_ax[ROOT_W]) << GAIN_FRAC_BITS;
      dv_d2[0] <= DIV_W'(span) + DIV_W'(1);
      dv_q2[0] <= '0;
    end
  end

  // ---------------- Dividers: one quotient bit per stage ----------------
  // Both quotients fit in QUO_W bits, so the shifted divisor test is exact.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int J = QUO_W - 1 - k;
    logic [DIV_W-1:0] sh1, sh2;
    logic             ge1, ge2;

    assign sh1 = dv_d1[k] << J;
    assign sh2 = dv_d2[k] << J;
    assign ge1 = dv_r1[k] >= sh1;
    assign ge2 = dv_r2[k] >= sh2;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_ctl[k+1].valid <= 1'b0;
      end else if (en) begin
        dv_ctl[k+1].valid <= dv_ctl[k].valid;
      end
      if (en) begin
        dv_ctl[k+1].spat <= dv_ctl[k].spat;
        dv_ctl[k+1].neg  <= dv_ctl[k].neg;
        dv_d1[k+1]       <= dv_d1[k];
        dv_d2[k+1]       <= dv_d2[k];
        dv_r1[k+1]       <= ge1 ? dv_r1[k] - sh1 : dv_r1[k];
        dv_r2[k+1]       <= ge2 ? dv_r2[k] - sh2 : dv_r2[k];
        dv_q1[k+1]       <= dv_q1[k] | (ge1 ? QUO_W'(1) << J : QUO_W'(0));
        dv_q2[k+1]       <= dv_q2[k] | (ge2 ? QUO_W'(1) << J : QUO_W'(0));
      end
    end
  end

  // ---------------- Output stage: pan split ----------------
  logic [GAIN_W-1:0] pmag;
  logic [GAIN_W:0]   lo_sum, hi_sum;
  out_word_t         gain_n;

  assign pmag   = (GAIN_W'(dv_q2[QUO_W]) > UNITY) ? UNITY : GAIN_W'(dv_q2[QUO_W]);
  assign hi_sum = (GAIN_W+1)'(UNITY) + (GAIN_W+1)'(pmag);
  assign lo_sum = (GAIN_W+1)'(UNITY) - (GAIN_W+1)'(pmag);

  always_comb begin
    if (!dv_ctl[QUO_W].spat) begin
      gain_n.distance_gain = UNITY;
      gain_n.left_gain     = UNITY;
      gain_n.right_gain    = UNITY;
    end else begin
      gain_n.distance_gain = GAIN_W'(dv_q1[QUO_W]);
      // negative dx pans left
      if (dv_ctl[QUO_W].neg) begin
        gain_n.left_gain  = hi_sum[GAIN_W:1];
        gain_n.right_gain = lo_sum[GAIN_W:1];
      end else begin
        gain_n.left_gain  = lo_sum[GAIN_W:1];
        gain_n.right_gain = hi_sum[GAIN_W:1];
      end
    end
  end

  logic out_spat;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_valid <= 1'b0;
    end else if (en) begin
      gain_valid <= dv_ctl[QUO_W].valid;
    end
    if (en) begin
      gain     <= gain_n;
      out_spat <= dv_ctl[QUO_W].spat;
    end
  end

  // ---------------- Assertions ----------------
  a_unity: assert property (@(posedge clk) disable iff (rst)
    gain_valid && !out_spat |->
      gain.distance_gain == UNITY && gain.left_gain == UNITY && gain.right_gain == UNITY)
    else $error("non-spatial word lost unity gains");

  a_pan_sum: assert property (@(posedge clk) disable iff (rst)
    gain_valid && out_spat |->
      ((GAIN_W+1)'(gain.left_gain) + (GAIN_W+1)'(gain.right_gain) == (GAIN_W+1)'(UNITY)) ||
      ((GAIN_W+1)'(gain.left_gain) + (GAIN_W+1)'(gain.right_gain) ==
       (GAIN_W+1)'(UNITY) - (GAIN_W+1)'(1)))
    else $error("left and right gains do not split unity");

  a_dgain: assert property (@(posedge clk) disable iff (rst)
    gain_valid && out_spat |-> gain.distance_gain <= UNITY)
    else $error("distance gain above unity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_ctl[QUO_W]) && $stable(dv_q1[QUO_W]) && $stable(sq_res[ROOT_W]))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
